FILE: rtl/gdet_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdet_pkg
// Shared constants and codes for the gamepad dead zone and edge tracker.
// ----------------------------------------------------------------------------
package gdet_pkg;

  localparam int PAD_COUNT = 4;
  localparam int PadW      = (PAD_COUNT > 1) ? $clog2(PAD_COUNT) : 1;

  localparam int PadIdxW   = 3;
  localparam int LinkW     = 2;
  localparam int AxisW     = 16;
  localparam int ButtonW   = 16;
  localparam int TrigW     = 8;
  localparam int ModeW     = 2;
  localparam int StatusW   = 2;
  localparam int CfgIdxW   = 2;
  localparam int CfgDataW  = 16;

  typedef enum logic [StatusW-1:0] {
    ST_OK      = 2'd0,
    ST_ABSENT  = 2'd1,
    ST_BAD_PAD = 2'd2
  } status_t;

  localparam logic [LinkW-1:0] LINK_UP     = 2'd0;
  localparam logic [LinkW-1:0] LINK_DOWN   = 2'd1;
  localparam logic [LinkW-1:0] LINK_ABSENT = 2'd2;

  localparam logic [ModeW-1:0] DZ_NONE   = 2'd0;
  localparam logic [ModeW-1:0] DZ_AXIS   = 2'd1;
  localparam logic [ModeW-1:0] DZ_CENTER = 2'd2;

  localparam logic [CfgIdxW-1:0] CFG_DZ_MODE   = 2'd0;
  localparam logic [CfgIdxW-1:0] CFG_LEFT_DZ   = 2'd1;
  localparam logic [CfgIdxW-1:0] CFG_RIGHT_DZ  = 2'd2;
  localparam logic [CfgIdxW-1:0] CFG_TRIG_THR  = 2'd3;

  localparam logic [ModeW-1:0]    RST_DZ_MODE  = DZ_NONE;
  localparam logic [AxisW-1:0]    RST_LEFT_DZ  = 16'd7849;
  localparam logic [AxisW-1:0]    RST_RIGHT_DZ = 16'd8689;
  localparam logic [TrigW-1:0]    RST_TRIG_THR = 8'd30;

endpackage
`default_nettype wire

FILE: rtl/gdet_in_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdet_in_if
// Report channel: one raw pad report per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdet_in_if import gdet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [PadIdxW-1:0]        pad_index;
  logic [LinkW-1:0]          link_status;
  logic signed [AxisW-1:0]   left_x;
  logic signed [AxisW-1:0]   left_y;
  logic signed [AxisW-1:0]   right_x;
  logic signed [AxisW-1:0]   right_y;
  logic [ButtonW-1:0]        button_word;
  logic [TrigW-1:0]          left_trigger;
  logic [TrigW-1:0]          right_trigger;

  modport source (
    output valid, pad_index, link_status, left_x, left_y, right_x, right_y,
           button_word, left_trigger, right_trigger,
    input  ready
  );
  modport sink (
    input  valid, pad_index, link_status, left_x, left_y, right_x, right_y,
           button_word, left_trigger, right_trigger,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/gdet_out_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gdet_out_if
// Result channel: one cleaned pad result per word, valid/ready handshake.
// ----------------------------------------------------------------------------
interface gdet_out_if import gdet_pkg::*; ();
  logic                      valid;
  logic                      ready;
  logic [StatusW-1:0]        status;
  logic                      is_connected;
  logic                      was_inserted;
  logic                      was_removed;
  logic signed [AxisW-1:0]   out_left_x;
  logic signed [AxisW-1:0]   out_left_y;
  logic signed [AxisW-1:0]   out_right_x;
  logic signed [AxisW-1:0]   out_right_y;
  logic [ButtonW-1:0]        held_buttons;
  logic [ButtonW-1:0]        new_presses;
  logic                      left_trigger_edge;
  logic                      right_trigger_edge;

  modport source (
    output valid, status, is_connected, was_inserted, was_removed,
           out_left_x, out_left_y, out_right_x, out_right_y,
           held_buttons, new_presses, left_trigger_edge, right_trigger_edge,
    input  ready
  );
  modport sink (
    input  valid, status, is_connected, was_inserted, was_removed,
           out_left_x, out_left_y, out_right_x, out_right_y,
           held_buttons, new_presses, left_trigger_edge, right_trigger_edge,
    output ready
  );
endinterface
`default_nettype wire

FILE: rtl/gamepad_deadzone_edge_tracker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gamepad_deadzone_edge_tracker
// Per-pad link tracking, stick dead zone, button and trigger edge detection.
// ----------------------------------------------------------------------------
//  channel   dir  handshake        word
//  in_ch     in   valid/ready      raw report (pad, link, sticks, buttons, triggers)
//  out_ch    out  valid/ready      cleaned result (status, link flags, sticks, edges)
//  cfg_*     in   cfg_we only      register index + data, no read-back
//
//  A word is registered on accept and its result once the result register is free,
//  which raises out_ch.valid. Throughput: one word per cycle while out_ch.ready
//  is high; per-pad history is read and written at the edge that loads the result,
//  so back-to-back words for one pad work.
//  Stalls: out_ch.ready low holds the result and the input register; in_ch.ready
//  stays high while the input register is empty or can move on. Reset clears all
//  pad history and loads the default register values.
// ----------------------------------------------------------------------------
module gamepad_deadzone_edge_tracker import gdet_pkg::*; (
  input  wire logic                clk,
  input  wire logic                rst_n,
  gdet_in_if.sink                  in_ch,
  gdet_out_if.source               out_ch,
  input  wire logic                cfg_we,
  input  wire logic [CfgIdxW-1:0]  cfg_index,
  input  wire logic [CfgDataW-1:0] cfg_wdata
);

  // configuration
  logic [ModeW-1:0] dz_mode_r;
  logic [AxisW-1:0] left_dz_r;
  logic [AxisW-1:0] right_dz_r;
  logic [TrigW-1:0] trig_thr_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dz_mode_r  <= RST_DZ_MODE;
      left_dz_r  <= RST_LEFT_DZ;
      right_dz_r <= RST_RIGHT_DZ;
      trig_thr_r <= RST_TRIG_THR;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_DZ_MODE:  dz_mode_r  <= cfg_wdata[ModeW-1:0];
        CFG_LEFT_DZ:  left_dz_r  <= cfg_wdata[AxisW-1:0];
        CFG_RIGHT_DZ: right_dz_r <= cfg_wdata[AxisW-1:0];
        CFG_TRIG_THR: trig_thr_r <= cfg_wdata[TrigW-1:0];
        default: ;
      endcase
    end
  end

  // input register
  logic                    s1_valid_r;
  logic [PadIdxW-1:0]      s1_pad_r;
  logic [LinkW-1:0]        s1_link_r;
  logic [AxisW-1:0]        s1_lx_r, s1_ly_r, s1_rx_r, s1_ry_r;
  logic [ButtonW-1:0]      s1_btn_r;
  logic [TrigW-1:0]        s1_lt_r, s1_rt_r;

  logic out_valid_r;
  logic out_free;
  logic s1_move;
  logic in_acc;

  assign out_free    = !out_valid_r || out_ch.ready;
  assign s1_move     = s1_valid_r && out_free;
  assign in_ch.ready = !s1_valid_r || out_free;
  assign in_acc      = in_ch.valid && in_ch.ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ch.ready) begin
      s1_valid_r <= in_ch.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_pad_r  <= in_ch.pad_index;
      s1_link_r <= in_ch.link_status;
      s1_lx_r   <= in_ch.left_x;
      s1_ly_r   <= in_ch.left_y;
      s1_rx_r   <= in_ch.right_x;
      s1_ry_r   <= in_ch.right_y;
      s1_btn_r  <= in_ch.button_word;
      s1_lt_r   <= in_ch.left_trigger;
      s1_rt_r   <= in_ch.right_trigger;
    end
  end

  // per-pad history
  logic [PAD_COUNT-1:0] conn_r;
  logic [ButtonW-1:0]   prev_btn_r [PAD_COUNT];
  logic [TrigW-1:0]     prev_lt_r  [PAD_COUNT];
  logic [TrigW-1:0]     prev_rt_r  [PAD_COUNT];

  function automatic logic [AxisW:0] mag(input logic [AxisW-1:0] v);
    logic [AxisW:0] ext;
    ext = {1'b0, v};
    return v[AxisW-1] ? ({1'b1, {AxisW{1'b0}}} - ext) : ext;
  endfunction

  // result logic
  logic [PadW-1:0]    idx;
  logic               pad_ok;
  logic               absent;
  logic               was;
  logic               now;
  logic [ButtonW-1:0] prev_btn;
  logic [TrigW-1:0]   prev_lt, prev_rt;
  logic               lx_in, ly_in, rx_in, ry_in;
  logic               lx_zero, ly_zero, rx_zero, ry_zero;

  assign idx    = s1_pad_r[PadW-1:0];
  assign pad_ok = {1'b0, s1_pad_r} < (PadIdxW+1)'(PAD_COUNT);
  assign absent = s1_link_r == LINK_ABSENT;
  assign was    = conn_r[idx];
  assign now    = s1_link_r == LINK_UP;

  // insertion starts from cleared history
  assign prev_btn = was ? prev_btn_r[idx] : '0;
  assign prev_lt  = was ? prev_lt_r[idx]  : '0;
  assign prev_rt  = was ? prev_rt_r[idx]  : '0;

  assign lx_in = mag(s1_lx_r) < {1'b0, left_dz_r};
  assign ly_in = mag(s1_ly_r) < {1'b0, left_dz_r};
  assign rx_in = mag(s1_rx_r) < {1'b0, right_dz_r};
  assign ry_in = mag(s1_ry_r) < {1'b0, right_dz_r};

  always_comb begin
    lx_zero = 1'b0;
    ly_zero = 1'b0;
    rx_zero = 1'b0;
    ry_zero = 1'b0;
    if (dz_mode_r == DZ_AXIS) begin
      lx_zero = lx_in;
      ly_zero = ly_in;
      rx_zero = rx_in;
      ry_zero = ry_in;
    end else if (dz_mode_r == DZ_CENTER) begin
      lx_zero = lx_in && ly_in;
      ly_zero = lx_in && ly_in;
      rx_zero = rx_in && ry_in;
      ry_zero = rx_in && ry_in;
    end
  end

  // result register
  logic [StatusW-1:0] status_r;
  logic               conn_out_r, ins_r, rem_r;
  logic [AxisW-1:0]   olx_r, oly_r, orx_r, ory_r;
  logic [ButtonW-1:0] held_r, press_r;
  logic               lt_edge_r, rt_edge_r;

  logic [StatusW-1:0] status_nxt;
  logic               conn_out_nxt, ins_nxt, rem_nxt;
  logic [AxisW-1:0]   olx_nxt, oly_nxt, orx_nxt, ory_nxt;
  logic [ButtonW-1:0] held_nxt, press_nxt;
  logic               lt_edge_nxt, rt_edge_nxt;

  always_comb begin
    status_nxt   = ST_OK;
    conn_out_nxt = 1'b0;
    ins_nxt      = 1'b0;
    rem_nxt      = 1'b0;
    olx_nxt      = '0;
    oly_nxt      = '0;
    orx_nxt      = '0;
    ory_nxt      = '0;
    held_nxt     = '0;
    press_nxt    = '0;
    lt_edge_nxt  = 1'b0;
    rt_edge_nxt  = 1'b0;
    if (!pad_ok) begin
      status_nxt = ST_BAD_PAD;
    end else if (absent) begin
      status_nxt = ST_ABSENT;
    end else begin
      conn_out_nxt = now;
      ins_nxt      = !was && now;
      rem_nxt      = was && !now;
      if (now) begin
        olx_nxt     = lx_zero ? '0 : s1_lx_r;
        oly_nxt     = ly_zero ? '0 : s1_ly_r;
        orx_nxt     = rx_zero ? '0 : s1_rx_r;
        ory_nxt     = ry_zero ? '0 : s1_ry_r;
        held_nxt    = s1_btn_r;
        press_nxt   = s1_btn_r & ~prev_btn;
        lt_edge_nxt = (s1_lt_r > trig_thr_r) && !(prev_lt > trig_thr_r);
        rt_edge_nxt = (s1_rt_r > trig_thr_r) && !(prev_rt > trig_thr_r);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_move) begin
      status_r   <= status_nxt;
      conn_out_r <= conn_out_nxt;
      ins_r      <= ins_nxt;
      rem_r      <= rem_nxt;
      olx_r      <= olx_nxt;
      oly_r      <= oly_nxt;
      orx_r      <= orx_nxt;
      ory_r      <= ory_nxt;
      held_r     <= held_nxt;
      press_r    <= press_nxt;
      lt_edge_r  <= lt_edge_nxt;
      rt_edge_r  <= rt_edge_nxt;
    end
  end

  // history update
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      conn_r <= '0;
      for (int p = 0; p < PAD_COUNT; p++) begin
        prev_btn_r[p] <= '0;
        prev_lt_r[p]  <= '0;
        prev_rt_r[p]  <= '0;
      end
    end else if (s1_move && pad_ok) begin
      if (absent) begin
        conn_r[idx]     <= 1'b0;
        prev_btn_r[idx] <= '0;
        prev_lt_r[idx]  <= '0;
        prev_rt_r[idx]  <= '0;
      end else begin
        conn_r[idx] <= now;
        if (now) begin
          prev_btn_r[idx] <= s1_btn_r;
          prev_lt_r[idx]  <= s1_lt_r;
          prev_rt_r[idx]  <= s1_rt_r;
        end
      end
    end
  end

  assign out_ch.valid              = out_valid_r;
  assign out_ch.status             = status_r;
  assign out_ch.is_connected       = conn_out_r;
  assign out_ch.was_inserted       = ins_r;
  assign out_ch.was_removed        = rem_r;
  assign out_ch.out_left_x         = olx_r;
  assign out_ch.out_left_y         = oly_r;
  assign out_ch.out_right_x        = orx_r;
  assign out_ch.out_right_y        = ory_r;
  assign out_ch.held_buttons       = held_r;
  assign out_ch.new_presses        = press_r;
  assign out_ch.left_trigger_edge  = lt_edge_r;
  assign out_ch.right_trigger_edge = rt_edge_r;

  // checks
  a_ins_rem_excl: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> !(ins_r && rem_r))
    else $error("insert and remove flagged together");

  a_disc_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !conn_out_r) |->
      (held_r == '0 && press_r == '0 && !lt_edge_r && !rt_edge_r && !ins_r))
    else $error("disconnected result carries button or trigger data");

  a_conn_tracks: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && pad_ok && !absent) |=> (conn_r[$past(idx)] == $past(now)))
    else $error("pad connected flag not updated from result");

  a_absent_clears: assert property (@(posedge clk) disable iff (!rst_n)
    (s1_move && pad_ok && absent) |=>
      (!conn_r[$past(idx)] && prev_btn_r[$past(idx)] == '0))
    else $error("driver absent did not clear pad history");

  a_ready_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !in_ch.ready |-> (s1_valid_r && out_valid_r && !out_ch.ready))
    else $error("input stalled without a full pipeline");

endmodule
`default_nettype wire
